>>> design/whp_pkg.sv
// Package: shared types, constants and the table functions of the hash rounds.
`timescale 1ns / 1ps
package whp_pkg;

	localparam int ROUNDS = 10;
	localparam int RND_W  = 4;

	typedef logic [0:7][63:0] lanes_t;

	// One compression job: a 64-byte block and whether it ends the message
	typedef struct packed {
		logic [511:0] blk;
		logic         fin;
	} job_t;

	localparam logic [3:0] MINI_E [16] = '{
		4'h1, 4'hB, 4'h9, 4'hC, 4'hD, 4'h6, 4'hF, 4'h3,
		4'hE, 4'h8, 4'h7, 4'h4, 4'hA, 4'h2, 4'h5, 4'h0
	};
	localparam logic [3:0] MINI_EI [16] = '{
		4'hF, 4'h0, 4'hD, 4'h7, 4'hB, 4'hE, 4'h5, 4'hA,
		4'h9, 4'h2, 4'hC, 4'h1, 4'h3, 4'h4, 4'h8, 4'h6
	};
	localparam logic [3:0] MINI_R [16] = '{
		4'h7, 4'hC, 4'hB, 4'hD, 4'hE, 4'h4, 4'h9, 4'hF,
		4'h6, 4'h3, 4'h8, 4'hA, 4'h2, 4'h5, 4'h1, 4'h0
	};

	function automatic logic [7:0] sbox(input logic [7:0] x);
		logic [3:0] a, b, r;
		a = MINI_E[x[7:4]];
		b = MINI_EI[x[3:0]];
		r = MINI_R[a ^ b];
		return {MINI_E[a ^ r], MINI_EI[b ^ r]};
	endfunction

	function automatic logic [7:0] gf_double(input logic [7:0] v);
		return {v[6:0], 1'b0} ^ (v[7] ? 8'h1D : 8'h00);
	endfunction

	// First column word of the circulant table
	function automatic logic [63:0] circ0(input logic [7:0] x);
		logic [7:0] s, s2, s4, s8;
		s  = sbox(x);
		s2 = gf_double(s);
		s4 = gf_double(s2);
		s8 = gf_double(s4);
		return {s, s, s4, s, s8, s4 ^ s, s2, s8 ^ s};
	endfunction

	// One W round without key addition
	function automatic lanes_t w_round(input lanes_t src);
		lanes_t     dst;
		logic [63:0] w;
		logic [127:0] dbl;
		dst = '0;
		for (int i = 0; i < 8; i++) begin
			for (int t = 0; t < 8; t++) begin
				w   = circ0(src[(i + 8 - t) & 7][63 - 8 * t -: 8]);
				dbl = {w, w} >> (8 * t);
				dst[i] = dst[i] ^ dbl[63:0];
			end
		end
		return dst;
	endfunction

	function automatic logic [63:0] round_const(input logic [RND_W-1:0] r);
		logic [63:0] w;
		logic [7:0]  base;
		w = '0;
		base = {1'b0, r - 4'd1, 3'b000};
		for (int i = 0; i < 8; i++) begin
			w = {w[55:0], sbox(base + 8'(i))};
		end
		return w;
	endfunction

endpackage

>>> design/whp_if.sv
// Interfaces: byte input channel and digest output channel.
`timescale 1ns / 1ps
interface whp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       has_byte;
	logic       is_last;
	modport source (output valid, data_byte, has_byte, is_last, input ready);
	modport sink (input valid, data_byte, has_byte, is_last, output ready);
endinterface

interface whp_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;
	modport source (output valid, digest_word, word_index, last_word, input ready);
	modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

>>> design/whp_fifo.sv
// Two-entry job queue between the gathering front and the compression back.
`timescale 1ns / 1ps
module whp_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  whp_pkg::job_t push_job,
	input  logic          push,
	input  logic          pop,
	output whp_pkg::job_t head,
	output logic          empty,
	output logic          full
);
	import whp_pkg::*;

	job_t       mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign empty = (cnt_q == 2'd0);
	assign full  = (cnt_q == 2'd2);
	assign head  = mem_q[rp_q];

	// Store pushed jobs
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= push_job;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

>>> design/whp_front.sv
// Front part: gather bytes into blocks, pad at message end, queue jobs.
`timescale 1ns / 1ps
module whp_front (
	input  logic           clk,
	input  logic           arst_n,
	whp_in_if.sink         byte_ch,
	input  logic           q_full,
	output whp_pkg::job_t  push_job,
	output logic           push
);
	import whp_pkg::*;

	logic [511:0] buf_q;
	logic [5:0]   pos_q;
	logic [63:0]  cnt_q;
	logic         pend_v_q;
	job_t         pend_q;

	logic [511:0] cur, padded, len_blk;
	logic [5:0]   p_new;
	logic [63:0]  cnt_new;
	logic         take, full_blk, extra;
	job_t         job_a, job_b;

	assign byte_ch.ready = !pend_v_q && !q_full;
	assign take = byte_ch.valid && byte_ch.ready;

	// Insert the incoming byte and build the padded block
	always_comb begin
		cur = buf_q;
		if (byte_ch.has_byte) begin
			cur[{~pos_q, 3'b000} +: 8] = byte_ch.data_byte;
		end
		p_new    = byte_ch.has_byte ? pos_q + 6'd1 : pos_q;
		cnt_new  = cnt_q + {60'd0, byte_ch.has_byte, 3'b000};
		full_blk = byte_ch.has_byte && (pos_q == 6'd63);
		extra    = !full_blk && p_new[5];
		len_blk  = {448'd0, cnt_new};
		for (int j = 0; j < 64; j++) begin
			if (6'(j) < p_new) padded[511 - 8 * j -: 8] = cur[511 - 8 * j -: 8];
			else if (6'(j) == p_new) padded[511 - 8 * j -: 8] = 8'h80;
			else padded[511 - 8 * j -: 8] = 8'h00;
		end
		if (full_blk) begin
			job_a = '{blk: cur, fin: 1'b0};
			job_b = '{blk: padded | len_blk, fin: 1'b1};
		end else if (extra) begin
			job_a = '{blk: padded, fin: 1'b0};
			job_b = '{blk: len_blk, fin: 1'b1};
		end else begin
			job_a = '{blk: padded | len_blk, fin: 1'b1};
			job_b = '{blk: len_blk, fin: 1'b1};
		end
	end

	assign push     = pend_v_q ? !q_full : (take && (full_blk || byte_ch.is_last));
	assign push_job = pend_v_q ? pend_q : job_a;

	// Hold the second job of a message end and the gathered block
	always_ff @(posedge clk) begin
		if (take) begin
			pend_q <= job_b;
			buf_q  <= cur;
		end
	end

	// Advance position and length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			cnt_q    <= '0;
			pend_v_q <= 1'b0;
		end else begin
			if (take) begin
				pos_q    <= byte_ch.is_last ? 6'd0 : p_new;
				cnt_q    <= byte_ch.is_last ? 64'd0 : cnt_new;
				pend_v_q <= byte_ch.is_last && (full_blk || extra);
			end else if (pend_v_q && !q_full) begin
				pend_v_q <= 1'b0;
			end
		end
	end
endmodule

>>> design/whp_back.sv
// Back part: compression rounds, feed-forward and digest output.
`timescale 1ns / 1ps
module whp_back (
	input  logic          clk,
	input  logic          arst_n,
	input  whp_pkg::job_t head,
	input  logic          empty,
	output logic          pop,
	whp_out_if.source     digest_ch
);
	import whp_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_KEY  = 4'b0010,
		ST_MIX  = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

	state_t          state_q;
	lanes_t          key_q, st_q, blk_q, cv_q;
	logic            fin_q;
	logic [RND_W-1:0] rnd_q;
	logic [2:0]      idx_q;
	logic            out_v_q;
	logic [63:0]     out_word_q;
	logic [2:0]      out_idx_q;
	logic            out_last_q;

	lanes_t wr_out, nst, key_nxt;
	logic   load_out;

	assign pop      = (state_q == ST_IDLE) && !empty;
	assign wr_out   = w_round((state_q == ST_KEY) ? key_q : st_q);
	assign nst      = wr_out ^ key_q;
	assign key_nxt  = wr_out ^ lanes_t'({round_const(rnd_q), 448'd0});
	assign load_out = (state_q == ST_EMIT) && (!out_v_q || digest_ch.ready);

	assign digest_ch.valid       = out_v_q;
	assign digest_ch.digest_word = out_word_q;
	assign digest_ch.word_index  = out_idx_q;
	assign digest_ch.last_word   = out_last_q;

	// Round datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				key_q <= cv_q;
				st_q  <= lanes_t'(head.blk) ^ cv_q;
				blk_q <= lanes_t'(head.blk);
				fin_q <= head.fin;
			end
			ST_KEY: key_q <= key_nxt;
			ST_MIX: st_q <= nst;
			ST_EMIT: ;
			default: ;
		endcase
		if (load_out) begin
			out_word_q <= cv_q[idx_q];
			out_idx_q  <= idx_q;
			out_last_q <= (idx_q == 3'd7);
		end
	end

	// Sequence rounds and digest words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cv_q    <= '0;
			rnd_q   <= '0;
			idx_q   <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (load_out) out_v_q <= 1'b1;
			else if (digest_ch.ready) out_v_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (!empty) begin
						rnd_q   <= RND_W'(1);
						state_q <= ST_KEY;
					end
				end
				ST_KEY: state_q <= ST_MIX;
				ST_MIX: begin
					if (rnd_q == RND_W'(ROUNDS)) begin
						cv_q    <= cv_q ^ nst ^ blk_q;
						idx_q   <= '0;
						state_q <= fin_q ? ST_EMIT : ST_IDLE;
					end else begin
						rnd_q   <= rnd_q + RND_W'(1);
						state_q <= ST_KEY;
					end
				end
				ST_EMIT: begin
					if (load_out) begin
						idx_q <= idx_q + 3'd1;
						if (idx_q == 3'd7) begin
							cv_q    <= '0;
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

>>> design/whirlpool_hash_engine.sv
// Top level: Whirlpool-512 hash engine over a byte stream.
// Throughput: one byte word per cycle while byte_ch.ready is high; a block runs through the
// shared round unit, alternating key and state rounds.
// The eight digest words follow one per cycle while the sink is ready.
// Reset clears chaining value, length, position, queue and output valid at once.
`timescale 1ns / 1ps
module whirlpool_hash_engine (
	input  logic      clk,
	input  logic      arst_n,
	whp_in_if.sink    byte_ch,
	whp_out_if.source digest_ch
);
	import whp_pkg::*;

	job_t   push_job, head;
	logic   q_push, q_full;
	logic   empty, pop;

	whp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.byte_ch  (byte_ch),
		.q_full   (q_full),
		.push_job (push_job),
		.push     (q_push)
	);

	whp_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_job (push_job),
		.push     (q_push),
		.pop      (pop),
		.head     (head),
		.empty    (empty),
		.full     (q_full)
	);

	whp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (empty),
		.pop       (pop),
		.digest_ch (digest_ch)
	);

	// Never push a full queue
	assert property (@(posedge clk) disable iff (!arst_n) q_push |-> !q_full)
		else $error("job pushed into full queue");

	// Final word flag only on the eighth word
	assert property (@(posedge clk) disable iff (!arst_n)
		digest_ch.valid |-> (digest_ch.last_word == (digest_ch.word_index == 3'd7)))
		else $error("last_word mismatch");

	// Word index advances after a taken non-final word
	assert property (@(posedge clk) disable iff (!arst_n)
		digest_ch.valid && digest_ch.ready && !digest_ch.last_word ##1 digest_ch.valid
		|-> digest_ch.word_index == $past(digest_ch.word_index) + 3'd1)
		else $error("digest word order broken");
endmodule

>>> tb/tb_whirlpool_hash_engine.sv
// Testbench: checks the Whirlpool-512 engine against a model of the hash, word by word.
`timescale 1ns / 1ps
module tb_whirlpool_hash_engine;
	import whp_pkg::*;

	localparam int STALL_LIMIT = 20000;

	typedef struct packed {
		logic [63:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} digest_t;

	logic clk;
	logic arst_n;

	whp_in_if  byte_ch ();
	whp_out_if digest_ch ();

	whirlpool_hash_engine dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_ch   (byte_ch.sink),
		.digest_ch (digest_ch.source)
	);

	// Hash model state
	logic [63:0] chain [8];
	logic [7:0]  msg_blk [64];
	int unsigned msg_pos;
	logic [63:0] msg_bits;
	logic [63:0] rc_tab [11];
	logic [63:0] circ_tab [256];
	logic [7:0]  sub_tab [256];

	digest_t digest_q [$];
	int      errors;
	int      idle_pct;
	bit      hold_off;
	int      quiet_cycles;

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Build S-box, circulant column and round constants from the mini boxes
	task automatic build_hash_tables();
		logic [3:0] e_inv [16];
		logic [3:0] a, b, r;
		logic [7:0] s, s2, s4, s8;
		logic [7:0] mini_e [16];
		logic [3:0] mini_r [16];
		mini_e = '{8'h1, 8'hB, 8'h9, 8'hC, 8'hD, 8'h6, 8'hF, 8'h3,
			8'hE, 8'h8, 8'h7, 8'h4, 8'hA, 8'h2, 8'h5, 8'h0};
		mini_r = '{4'h7, 4'hC, 4'hB, 4'hD, 4'hE, 4'h4, 4'h9, 4'hF,
			4'h6, 4'h3, 4'h8, 4'hA, 4'h2, 4'h5, 4'h1, 4'h0};
		for (int i = 0; i < 16; i++) e_inv[mini_e[i][3:0]] = 4'(i);
		for (int x = 0; x < 256; x++) begin
			a = mini_e[x >> 4][3:0];
			b = e_inv[x & 15];
			r = mini_r[a ^ b];
			sub_tab[x] = {mini_e[a ^ r][3:0], e_inv[b ^ r]};
		end
		for (int x = 0; x < 256; x++) begin
			s  = sub_tab[x];
			s2 = {s[6:0], 1'b0} ^ (s[7] ? 8'h1D : 8'h00);
			s4 = {s2[6:0], 1'b0} ^ (s2[7] ? 8'h1D : 8'h00);
			s8 = {s4[6:0], 1'b0} ^ (s4[7] ? 8'h1D : 8'h00);
			circ_tab[x] = {s, s, s4, s, s8, s4 ^ s, s2, s8 ^ s};
		end
		rc_tab[0] = '0;
		for (int k = 1; k <= 10; k++)
			for (int i = 0; i < 8; i++)
				rc_tab[k] = {rc_tab[k][55:0], sub_tab[8 * (k - 1) + i]};
	endtask

	function automatic void mix_lanes(input logic [63:0] src [8], output logic [63:0] dst [8]);
		logic [63:0]  col;
		logic [127:0] dbl;
		for (int i = 0; i < 8; i++) begin
			dst[i] = '0;
			for (int t = 0; t < 8; t++) begin
				col = circ_tab[src[(i + 8 - t) & 7][63 - 8 * t -: 8]];
				dbl = {col, col} >> (8 * t);
				dst[i] ^= dbl[63:0];
			end
		end
	endfunction

	// Compress the held block into the chaining value
	task automatic compress_block();
		logic [63:0] blk [8], key [8], st [8], tmp [8];
		for (int i = 0; i < 8; i++) begin
			blk[i] = '0;
			for (int j = 0; j < 8; j++) blk[i] = {blk[i][55:0], msg_blk[8 * i + j]};
			key[i] = chain[i];
			st[i]  = blk[i] ^ key[i];
		end
		for (int r = 1; r <= ROUNDS; r++) begin
			mix_lanes(key, tmp);
			tmp[0] ^= rc_tab[r];
			key = tmp;
			mix_lanes(st, tmp);
			for (int i = 0; i < 8; i++) st[i] = tmp[i] ^ key[i];
		end
		for (int i = 0; i < 8; i++) chain[i] ^= st[i] ^ blk[i];
	endtask

	task automatic clear_hash();
		for (int i = 0; i < 8; i++) chain[i] = '0;
		msg_pos  = 0;
		msg_bits = '0;
	endtask

	// Advance the hash model by one accepted word and queue any digest
	task automatic hash_word(input logic [7:0] data, input logic has, input logic fin);
		int unsigned p;
		digest_t d;
		if (has) begin
			msg_blk[msg_pos] = data;
			msg_pos  = (msg_pos + 1) & 63;
			msg_bits += 64'd8;
			if (msg_pos == 0) compress_block();
		end
		if (!fin) return;
		p = msg_pos;
		msg_blk[p] = 8'h80;
		p++;
		if (p > 32) begin
			for (int i = p; i < 64; i++) msg_blk[i] = '0;
			compress_block();
			p = 0;
		end
		for (int i = p; i < 56; i++) msg_blk[i] = '0;
		for (int i = 0; i < 8; i++) msg_blk[56 + i] = msg_bits[63 - 8 * i -: 8];
		compress_block();
		for (int i = 0; i < 8; i++) begin
			d.digest_word = chain[i];
			d.word_index  = 3'(i);
			d.last_word   = (i == 7);
			digest_q.push_back(d);
		end
		clear_hash();
	endtask

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		errors++;
		$display("MISMATCH %s: got %h, expected %h", what, got, want);
	endtask

	// Offer one word and hold until it is taken
	task automatic send_byte(input logic [7:0] data, input logic has, input logic fin);
		while (($urandom_range(99) < idle_pct)) begin
			byte_ch.valid <= 1'b0;
			@(negedge clk);
		end
		byte_ch.valid     <= 1'b1;
		byte_ch.data_byte <= data;
		byte_ch.has_byte  <= has;
		byte_ch.is_last   <= fin;
		do @(posedge clk); while (!byte_ch.ready);
		hash_word(data, has, fin);
		@(negedge clk);
	endtask

	task automatic send_message(input int len, input logic tail_empty);
		for (int i = 0; i < len; i++)
			send_byte(8'($urandom), 1'b1, (i == len - 1) && !tail_empty);
		if (tail_empty || len == 0) send_byte(8'($urandom), 1'b0, 1'b1);
	endtask

	task automatic wait_drained();
		byte_ch.valid <= 1'b0;
		while (digest_q.size() != 0) @(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	// Empty message, pad boundaries, extreme bytes and empty words
	task automatic test_directed();
		send_byte(8'h00, 1'b0, 1'b1);
		send_byte(8'hFF, 1'b1, 1'b1);
		send_byte(8'h00, 1'b1, 1'b0);
		send_byte(8'hAA, 1'b0, 1'b0);
		send_byte(8'h55, 1'b1, 1'b1);
		send_message(31, 1'b0);
		send_message(32, 1'b1);
		send_message(33, 1'b0);
		wait_drained();
	endtask

	// Block boundaries: last byte fills a block, and a full block then an empty end
	task automatic test_block_edges();
		send_message(64, 1'b0);
		send_message(64, 1'b1);
		wait_drained();
	endtask

	// Random messages, short and long, with stray empty words
	task automatic test_random_messages();
		int sent;
		int len;
		sent = 0;
		while (sent < 50) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(65, 80) : $urandom_range(0, 20);
			if ($urandom_range(5) == 0) send_byte(8'($urandom), 1'b0, 1'b0);
			send_message(len, 1'(($urandom_range(3) == 0)));
			sent += len + 1;
		end
		wait_drained();
	endtask

	// Stall the output long enough for the input to back up
	task automatic test_back_pressure();
		hold_off = 1'b1;
		for (int m = 0; m < 6; m++) send_message(4, 1'b0);
		hold_off = 1'b0;
		wait_drained();
	endtask

	// Sink: idle at random, or when asked hold ready low, then keep it high until released
	initial begin
		int hold;
		digest_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) begin
				digest_ch.ready <= 1'b0;
				hold = 0;
				while (hold < 400) begin
					@(negedge clk);
					hold++;
				end
				digest_ch.ready <= 1'b1;
				while (hold_off) @(negedge clk);
			end else begin
				digest_ch.ready <= ($urandom_range(99) >= idle_pct);
			end
		end
	end

	// Check each digest word against the oldest expectation
	always @(posedge clk) begin
		digest_t want;
		if (arst_n && digest_ch.valid && digest_ch.ready) begin
			if (digest_q.size() == 0) begin
				report_mismatch("unexpected digest_word", digest_ch.digest_word, '0);
			end else begin
				want = digest_q.pop_front();
				if (digest_ch.digest_word !== want.digest_word)
					report_mismatch("digest_word", digest_ch.digest_word, want.digest_word);
				if (digest_ch.word_index !== want.word_index)
					report_mismatch("word_index", digest_ch.word_index, want.word_index);
				if (digest_ch.last_word !== want.last_word)
					report_mismatch("last_word", digest_ch.last_word, want.last_word);
			end
		end
	end

	// Watchdog on cycles with no accepted word
	always @(posedge clk) begin
		if ((byte_ch.valid && byte_ch.ready) || (digest_ch.valid && digest_ch.ready)
			|| !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > STALL_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		errors            = 0;
		quiet_cycles      = 0;
		hold_off          = 1'b0;
		idle_pct          = 18;
		arst_n            = 1'b0;
		byte_ch.valid     = 1'b0;
		byte_ch.data_byte = '0;
		byte_ch.has_byte  = 1'b0;
		byte_ch.is_last   = 1'b0;
		build_hash_tables();
		clear_hash();
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_block_edges();
		// No idling for a stretch
		idle_pct = 0;
		for (int m = 0; m < 2; m++) send_message(35, 1'b0);
		wait_drained();
		idle_pct = 18;
		test_random_messages();
		test_back_pressure();
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule

>>> sim.f
design/whp_pkg.sv
design/whp_if.sv
design/whp_fifo.sv
design/whp_front.sv
design/whp_back.sv
design/whirlpool_hash_engine.sv
tb/tb_whirlpool_hash_engine.sv
